[hdl/rmq_pkg.sv]
`timescale 1ns / 1ps
// Package for the rotation-matrix-to-quaternion pipeline.
// Holds widths, data types and the stage payload structs; no dependencies.
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // t and the raw components, signed
  localparam int TW = ((FRAC_BITS + 2 > DATA_WIDTH) ? FRAC_BITS + 2 : DATA_WIDTH) + 2;
  // magnitude of a raw component
  localparam int MW = TW - 1;
  // radicand t * 2^FRAC_BITS
  localparam int XW = MW + FRAC_BITS;
  // square root width
  localparam int RW = (XW + 1) / 2;
  // dividend |raw| * 2^(FRAC_BITS-1) + r/2
  localparam int NW = MW + FRAC_BITS;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    logic                  bad;
    logic [3:0]            neg;
    logic [3:0][MW-1:0]    mag;
    logic [2*RW-1:0]       rad;
    logic [RW:0]           rem;
    logic [RW-1:0]         root;
  } sqrt_t;

  typedef struct packed {
    logic                  bad;
    logic [3:0]            neg;
    logic [RW-1:0]         dvs;
    logic [3:0][NW-1:0]    num;
    logic [3:0][RW-1:0]    rem;
    logic [3:0][NW-1:0]    quo;
  } div_t;

endpackage

[hdl/rmq_in_if.sv]
`timescale 1ns / 1ps
// Input channel: valid/ready handshake carrying the nine matrix entries.
// Depends on rmq_pkg.
interface rmq_in_if;
  import rmq_pkg::*;
  logic  valid;
  logic  ready;
  data_t entry_r0_c0, entry_r0_c1, entry_r0_c2;
  data_t entry_r1_c0, entry_r1_c1, entry_r1_c2;
  data_t entry_r2_c0, entry_r2_c1, entry_r2_c2;

  modport source (output valid, entry_r0_c0, entry_r0_c1, entry_r0_c2,
                  entry_r1_c0, entry_r1_c1, entry_r1_c2,
                  entry_r2_c0, entry_r2_c1, entry_r2_c2, input ready);
  modport sink (input valid, entry_r0_c0, entry_r0_c1, entry_r0_c2,
                entry_r1_c0, entry_r1_c1, entry_r1_c2,
                entry_r2_c0, entry_r2_c1, entry_r2_c2, output ready);
endinterface

[hdl/rmq_out_if.sv]
`timescale 1ns / 1ps
// Output channel: valid/ready handshake carrying the quaternion and error flag.
// Depends on rmq_pkg.
interface rmq_out_if;
  import rmq_pkg::*;
  logic  valid;
  logic  ready;
  data_t quat_first, quat_second, quat_third, quat_fourth;
  logic  bad_trace;

  modport source (output valid, quat_first, quat_second, quat_third, quat_fourth,
                  bad_trace, input ready);
  modport sink (input valid, quat_first, quat_second, quat_third, quat_fourth,
                bad_trace, output ready);
endinterface

[hdl/rotation_matrix_to_quaternion.sv]
`timescale 1ns / 1ps
// Rotation matrix to quaternion (Day's method), Q2.14 in and out.
// Pipeline: one front stage, one stage per square-root digit, one stage per
// quotient bit, and one output register.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset: rst_ni clears the valid bits only; data registers are not reset.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmq_in_if.sink    in_i,
  rmq_out_if.source out_o
);

  // Advance every stage together unless a finished result is stuck at the output.
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // Root chain: front stage, then one stage per root bit.
  logic  sq_valid [RW+1];
  sqrt_t sq_data  [RW+1];

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .m00_i   (in_i.entry_r0_c0), .m01_i (in_i.entry_r0_c1), .m02_i (in_i.entry_r0_c2),
    .m10_i   (in_i.entry_r1_c0), .m11_i (in_i.entry_r1_c1), .m12_i (in_i.entry_r1_c2),
    .m20_i   (in_i.entry_r2_c0), .m21_i (in_i.entry_r2_c1), .m22_i (in_i.entry_r2_c2),
    .valid_o (sq_valid[0]),
    .data_o  (sq_data[0])
  );

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    rmq_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[i]),
      .data_i  (sq_data[i]),
      .valid_o (sq_valid[i+1]),
      .data_o  (sq_data[i+1])
    );
  end

  // Divider set-up: dividend is |raw| * 2^(FRAC_BITS-1) plus half the root,
  // which gives round-half-away once the sign is put back.
  logic          dv_valid [NW+1];
  div_t          dv_data  [NW+1];
  logic [RW-1:0] root;

  always_comb begin
    root = (sq_data[RW].root == '0) ? RW'(1) : sq_data[RW].root;
    dv_data[0].bad = sq_data[RW].bad;
    dv_data[0].neg = sq_data[RW].neg;
    dv_data[0].dvs = root;
    dv_data[0].rem = '0;
    dv_data[0].quo = '0;
    for (int k = 0; k < 4; k++) begin
      dv_data[0].num[k] = (NW'(sq_data[RW].mag[k]) << (FRAC_BITS - 1)) + NW'(root >> 1);
    end
  end
  assign dv_valid[0] = sq_valid[RW];

  for (genvar j = 0; j < NW; j++) begin : g_div
    rmq_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[j]),
      .data_i  (dv_data[j]),
      .valid_o (dv_valid[j+1]),
      .data_o  (dv_data[j+1])
    );
  end

  // Saturate each quotient to the signed output range and apply the sign.
  localparam logic [NW-1:0] QMAX = {{(NW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [NW-1:0] QMIN = QMAX + NW'(1);
  localparam data_t POS_SAT = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t NEG_SAT = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  data_t quat_d [4];
  data_t quat_q [4];
  logic  bad_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (dv_data[NW].bad) begin
        quat_d[k] = '0;
      end else if (!dv_data[NW].neg[k]) begin
        quat_d[k] = (dv_data[NW].quo[k] > QMAX) ? POS_SAT :
                    data_t'(dv_data[NW].quo[k][DATA_WIDTH-1:0]);
      end else begin
        quat_d[k] = (dv_data[NW].quo[k] > QMIN) ? NEG_SAT :
                    data_t'(-dv_data[NW].quo[k][DATA_WIDTH-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      quat_q <= quat_d;
      bad_q  <= dv_data[NW].bad;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.quat_first  = quat_q[0];
  assign out_o.quat_second = quat_q[1];
  assign out_o.quat_third  = quat_q[2];
  assign out_o.quat_fourth = quat_q[3];
  assign out_o.bad_trace   = bad_q;

endmodule

[hdl/rmq_front.sv]
`timescale 1ns / 1ps
// Front stage: case choice, t and raw components, radicand set-up.
// Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  data_t m00_i, m01_i, m02_i,
  input  data_t m10_i, m11_i, m12_i,
  input  data_t m20_i, m21_i, m22_i,
  output logic  valid_o,
  output sqrt_t data_o
);

  localparam logic signed [TW-1:0] ONE = {{(TW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [TW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, t;
  logic signed [TW-1:0] raw [4];
  logic  valid_q;
  sqrt_t data_d, data_q;

  always_comb begin
    m00 = TW'(m00_i); m01 = TW'(m01_i); m02 = TW'(m02_i);
    m10 = TW'(m10_i); m11 = TW'(m11_i); m12 = TW'(m12_i);
    m20 = TW'(m20_i); m21 = TW'(m21_i); m22 = TW'(m22_i);
    if (m22 < 0) begin
      if (m00 > m11) begin
        t = ONE + m00 - m11 - m22;
        raw[0] = t; raw[1] = m10 + m01; raw[2] = m02 + m20; raw[3] = m21 - m12;
      end else begin
        t = ONE - m00 + m11 - m22;
        raw[0] = m10 + m01; raw[1] = t; raw[2] = m21 + m12; raw[3] = m02 - m20;
      end
    end else begin
      if (m00 < -m11) begin
        t = ONE - m00 - m11 + m22;
        raw[0] = m02 + m20; raw[1] = m21 + m12; raw[2] = t; raw[3] = m10 - m01;
      end else begin
        t = ONE + m00 + m11 + m22;
        raw[0] = m21 - m12; raw[1] = m02 - m20; raw[2] = m10 - m01; raw[3] = t;
      end
    end
    data_d.bad = (t <= 0);
    for (int k = 0; k < 4; k++) begin
      data_d.neg[k] = raw[k][TW-1];
      data_d.mag[k] = raw[k][TW-1] ? MW'(-raw[k]) : MW'(raw[k]);
    end
    // drop the radicand to zero on a bad trace so the root stays defined
    data_d.rad  = data_d.bad ? '0 : ((2*RW)'(t[MW-1:0]) << FRAC_BITS);
    data_d.rem  = '0;
    data_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hdl/rmq_sqrt_stage.sv]
`timescale 1ns / 1ps
// One digit of the integer square root: two radicand bits, one root bit.
// Depends on rmq_pkg.
module rmq_sqrt_stage import rmq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  sqrt_t data_i,
  output logic  valid_o,
  output sqrt_t data_o
);

  logic [RW+1:0] trial, cand;
  logic          ge;
  logic          valid_q;
  sqrt_t         data_d, data_q;

  always_comb begin
    trial  = {data_i.rem[RW-1:0], data_i.rad[2*RW-1 -: 2]};
    cand   = {data_i.root, 2'b01};
    ge     = (trial >= cand);
    data_d = data_i;
    data_d.rad  = data_i.rad << 2;
    data_d.rem  = ge ? (RW+1)'(trial - cand) : (RW+1)'(trial);
    data_d.root = {data_i.root[RW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hdl/rmq_div_stage.sv]
`timescale 1ns / 1ps
// One quotient bit of a restoring divide, four lanes sharing one divisor.
// Depends on rmq_pkg.
module rmq_div_stage import rmq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  logic [RW:0] trial [4];
  logic [3:0]  ge;
  logic        valid_q;
  div_t        data_d, data_q;

  always_comb begin
    data_d = data_i;
    for (int k = 0; k < 4; k++) begin
      trial[k] = {data_i.rem[k], data_i.num[k][NW-1]};
      ge[k]    = (trial[k] >= {1'b0, data_i.dvs});
      data_d.rem[k] = ge[k] ? RW'(trial[k] - {1'b0, data_i.dvs}) : RW'(trial[k]);
      data_d.num[k] = data_i.num[k] << 1;
      data_d.quo[k] = {data_i.quo[k][NW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sim/rotation_matrix_to_quaternion_test.sv]
`timescale 1ns / 1ps
// Testbench for rotation_matrix_to_quaternion: random and directed matrices,
// checked against an integer predictor. Depends on rmq_pkg, rmq_in_if, rmq_out_if.

class quat_scoreboard;
  typedef struct packed {
    logic [15:0] x, y, z, w;
    logic        bad;
  } quat_t;

  quat_t pending_q[$];
  int    mismatches;

  function automatic longint isqrt(longint v);
    longint res, bit_v;
    res = 0;
    bit_v = 64'sd1 << 60;
    while (bit_v > v) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] scale_sat(longint raw, longint r);
    longint mag, q;
    mag = (raw < 0) ? -raw : raw;
    q = (mag * (64'sd1 << (rmq_pkg::FRAC_BITS - 1)) + (r >>> 1)) / r;
    if (raw < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Note an accepted request: predict its quaternion and queue it.
  function void note_request(logic signed [15:0] m[9]);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, t, r;
    longint raw[4];
    quat_t e;
    a00 = m[0]; a01 = m[1]; a02 = m[2];
    a10 = m[3]; a11 = m[4]; a12 = m[5];
    a20 = m[6]; a21 = m[7]; a22 = m[8];
    if (a22 < 0) begin
      if (a00 > a11) begin
        t = 16384 + a00 - a11 - a22;
        raw = '{t, a10 + a01, a02 + a20, a21 - a12};
      end else begin
        t = 16384 - a00 + a11 - a22;
        raw = '{a10 + a01, t, a21 + a12, a02 - a20};
      end
    end else if (a00 < -a11) begin
      t = 16384 - a00 - a11 + a22;
      raw = '{a02 + a20, a21 + a12, t, a10 - a01};
    end else begin
      t = 16384 + a00 + a11 + a22;
      raw = '{a21 - a12, a02 - a20, a10 - a01, t};
    end
    if (t <= 0) begin
      e = '0;
      e.bad = 1'b1;
    end else begin
      r = isqrt(t << rmq_pkg::FRAC_BITS);
      if (r == 0) r = 1;
      e.x = scale_sat(raw[0], r);
      e.y = scale_sat(raw[1], r);
      e.z = scale_sat(raw[2], r);
      e.w = scale_sat(raw[3], r);
      e.bad = 1'b0;
    end
    pending_q.push_back(e);
  endfunction

  function void check_result(quat_t got);
    quat_t e;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected quaternion %h", got);
      return;
    end
    e = pending_q.pop_front();
    if (got !== e) begin
      mismatches++;
      if (mismatches <= 10)
        $display("quaternion mismatch: expected %h %h %h %h bad %b, got %h %h %h %h bad %b",
                 e.x, e.y, e.z, e.w, e.bad, got.x, got.y, got.z, got.w, got.bad);
    end
  endfunction
endclass

module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  localparam int LATENCY = 2 + RW + NW;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_idle_pct;
  longint cycle_count;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  quat_scoreboard quat_sb = new();

  rotation_matrix_to_quaternion DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hold every input at a known value until the driver takes over.
  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.entry_r0_c0, in_ch.entry_r0_c1, in_ch.entry_r0_c2,
     in_ch.entry_r1_c0, in_ch.entry_r1_c1, in_ch.entry_r1_c2,
     in_ch.entry_r2_c0, in_ch.entry_r2_c1, in_ch.entry_r2_c2} = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Stall the receiver at random; check each result taken on a handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        quat_sb.check_result({out_ch.quat_first, out_ch.quat_second, out_ch.quat_third,
                              out_ch.quat_fourth, out_ch.bad_trace});
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Abort on a hung pipeline.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drive one request, idling first at the sender's rate, and wait for acceptance.
  task automatic send_matrix(logic signed [15:0] m[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.entry_r0_c0, in_ch.entry_r0_c1, in_ch.entry_r0_c2,
     in_ch.entry_r1_c0, in_ch.entry_r1_c1, in_ch.entry_r1_c2,
     in_ch.entry_r2_c0, in_ch.entry_r2_c1, in_ch.entry_r2_c2}
      <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    do @(posedge clk_i); while (!in_ch.ready);
    quat_sb.note_request(m);
  endtask

  // Random entry: spread evenly around zero, up to half the scale either way, signed.
  function automatic logic signed [15:0] near_entry(int scale);
    return $signed(16'($urandom_range(scale))) - 16'(scale / 2);
  endfunction

  task automatic send_random_matrix();
    logic signed [15:0] m[9];
    int kind;
    kind = $urandom_range(9);
    for (int k = 0; k < 9; k++) begin
      if (kind < 6) m[k] = near_entry(32768);
      else if (kind < 9) m[k] = $signed(16'($urandom()));
      else m[k] = ($urandom_range(1)) ? 16'sh7fff : -16'sh8000;
    end
    // Lean diagonal toward each case on well-formed rotations.
    if (kind < 3) m[$urandom_range(2) * 4] = 16'(16384 - $urandom_range(4000));
    send_matrix(m);
  endtask

  initial begin
    logic signed [15:0] m[9];
    cycle_count = 0;
    send_idle_pct = 27;
    recv_idle_pct = 57;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Identity and the three half-turns: one matrix for each case.
    m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_matrix(m);
    m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(m);
    m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(m);
    m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(m);
    // Quarter turn about z with off-diagonals in play.
    m = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}; send_matrix(m);
    // Matrices far from a rotation; t stays positive, so no bad trace.
    m = '{-32768, 5, 7, 9, -32768, 11, 13, 15, 0}; send_matrix(m);
    m = '{-16384, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
    // Field extremes: saturation and t at its lower bound of one.
    m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}; send_matrix(m);
    m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    send_matrix(m);
    m = '{-16383, 32767, 32767, 32767, 0, 32767, 32767, 32767, 0}; send_matrix(m);
    m = '{0, -32768, 32767, 32767, 0, -32768, -32768, 32767, -1}; send_matrix(m);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, -1}; send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 57 : 0;
      recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 27 : 0;
      repeat (512) send_random_matrix();
    end
    in_ch.valid <= 1'b0;

    wait (quat_sb.pending_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (quat_sb.mismatches == 0 && quat_sb.pending_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
